// File: src/lfme_pkg.sv
// ----------------------------------------------------------------------------
// lfme_pkg
// shared types, token codes and helpers for the first-match lzss encoder
// ----------------------------------------------------------------------------
package lfme_pkg;

	localparam int SEARCH_DEPTH_DEF    = 2048;
	localparam int LOOKAHEAD_DEPTH_DEF = 256;

	// token kinds
	localparam logic [1:0] KIND_LITERAL = 2'd0;
	localparam logic [1:0] KIND_REF     = 2'd1;
	localparam logic [1:0] KIND_COPY    = 2'd2;

	// text form "(offset,length)" has two brackets and a comma
	localparam int TEXT_PUNCT = 3;

	typedef struct packed {
		logic       func;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  token_kind;
		logic [11:0] match_offset;
		logic [8:0]  match_length;
		logic [7:0]  literal_byte;
		logic        is_final;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic take;     // an input transfer happens
		logic push;     // store the byte in the look-ahead
		logic init;     // set up the scan pointers
		logic read;     // fetch both compare operands
		logic compare;  // act on the fetched operands
		logic emit;     // load the token and consume bytes
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic look_empty;
		logic look_almost_full;
		logic scan_done;
		logic out_free;
	} stat_t;

	// number of decimal digits of a value below one million
	function automatic logic [2:0] dec_digits(input logic [31:0] v);
		logic [2:0] n;
		if (v >= 32'd100000)
			n = 3'd6;
		else if (v >= 32'd10000)
			n = 3'd5;
		else if (v >= 32'd1000)
			n = 3'd4;
		else if (v >= 32'd100)
			n = 3'd3;
		else if (v >= 32'd10)
			n = 3'd2;
		else
			n = 3'd1;
		return n;
	endfunction

endpackage

// File: src/lzss_first_match_encoder_unit.sv
// ----------------------------------------------------------------------------
// lzss_first_match_encoder_unit
// lzss encoder that reports the first history match, not the longest
// ----------------------------------------------------------------------------
//  channel  signals                          transfer when
//  in       in_valid, in_stall, in_data      in_valid && !in_stall
//  out      out_valid, out_stall, out_data   out_valid && !out_stall
//
//  a push that does not fill the look-ahead leaves the unit ready for the next item
//  a token runs an init step, then a read and a compare step per compare, then
//  an emit step that waits for the out slot; the single-port-per-operand ring
//  buffer read sets the read step before each compare
//  arst_n clears fills, the look-ahead start pointer and out_valid; buffer contents need no clearing
//  in_stall is high while a token is worked out or waits for the out slot
//  a finished token sits in the out register while the next item is taken
module lzss_first_match_encoder_unit #(
	parameter int SEARCH_DEPTH    = lfme_pkg::SEARCH_DEPTH_DEF,
	parameter int LOOKAHEAD_DEPTH = lfme_pkg::LOOKAHEAD_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  lfme_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output lfme_pkg::out_item_t out_data
);
	import lfme_pkg::*;

	cmd_t  cmd;
	stat_t st;

	// sequencer for accept, scan loop and emit
	lfme_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_func  (in_data.func),
		.st       (st),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	// ring buffer holds history followed by look-ahead, so consuming is a pointer move
	lfme_dp #(
		.SEARCH_DEPTH    (SEARCH_DEPTH),
		.LOOKAHEAD_DEPTH (LOOKAHEAD_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.out_stall (out_stall),
		.st        (st),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

`ifndef SYNTHESIS
	// a token is only loaded when the out slot is free
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> st.out_free) else $error("token loaded over a pending transfer");

	// a push that fills the look-ahead starts a scan
	a_full_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take && !in_data.func && st.look_almost_full |=> in_stall)
		else $error("full look-ahead did not start a scan");

	// a flush with an empty look-ahead produces nothing
	a_empty_flush: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take && in_data.func && st.look_empty |=> !in_stall)
		else $error("flush on empty look-ahead started a scan");
`endif

endmodule

// File: src/lfme_ctrl.sv
// ----------------------------------------------------------------------------
// lfme_ctrl
// sequencer: takes items, runs the scan loop and hands tokens out
// ----------------------------------------------------------------------------
module lfme_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_func,
	input  lfme_pkg::stat_t st,
	output logic            in_stall,
	output lfme_pkg::cmd_t  cmd
);
	import lfme_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_INIT = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_CMP  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       take;

	assign in_stall = (state_q != ST_IDLE);
	assign take     = in_valid && !in_stall;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.take    = take;
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					if (!in_func) begin
						cmd.push = 1'b1;
						if (st.look_almost_full)
							state_d = ST_INIT;
					end else if (!st.look_empty) begin
						state_d = ST_INIT;
					end
				end
			end
			ST_INIT: begin
				cmd.init = 1'b1;
				state_d  = ST_RD;
			end
			ST_RD: begin
				cmd.read = 1'b1;
				state_d  = ST_CMP;
			end
			ST_CMP: begin
				cmd.compare = 1'b1;
				state_d     = st.scan_done ? ST_EMIT : ST_RD;
			end
			ST_EMIT: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// File: src/lfme_dp.sv
// ----------------------------------------------------------------------------
// lfme_dp
// datapath: ring buffer of history and look-ahead, scan pointers, token register
// ----------------------------------------------------------------------------
module lfme_dp #(
	parameter int SEARCH_DEPTH    = lfme_pkg::SEARCH_DEPTH_DEF,
	parameter int LOOKAHEAD_DEPTH = lfme_pkg::LOOKAHEAD_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lfme_pkg::cmd_t      cmd,
	input  lfme_pkg::in_item_t  in_data,
	input  logic                out_stall,
	output lfme_pkg::stat_t     st,
	output logic                out_valid,
	output lfme_pkg::out_item_t out_data
);
	import lfme_pkg::*;

	localparam int RING = SEARCH_DEPTH + LOOKAHEAD_DEPTH;
	localparam int AW   = $clog2(RING);
	localparam int HFW  = $clog2(SEARCH_DEPTH + 1);
	localparam int LFW  = $clog2(LOOKAHEAD_DEPTH + 1);
	localparam logic [AW:0] RING_W = (AW + 1)'(RING);

	logic [7:0]    ring_q [RING];
	logic [7:0]    rd_a_q, rd_b_q;
	logic [AW-1:0] lh_start_q, ptr_i_q, scan_ptr_q, look_ptr_q;
	logic [HFW-1:0] hist_fill_q, i_q;
	logic [LFW-1:0] look_fill_q, k_q, res_len_q;
	logic [HFW-1:0] res_off_q;
	logic [1:0]    res_kind_q;
	logic [7:0]    res_lit_q;
	logic          flush_q;
	logic          out_valid_q;
	out_item_t     out_q;

	logic [AW:0]   wr_sum, oldest_sum, start_sum;
	logic [AW-1:0] wr_addr, oldest, start_nxt;
	logic          eq, no_hist, k_more, i_more;
	logic [3:0]    text_len;
	logic [31:0]   hist_sum;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
		return (p == AW'(RING - 1)) ? '0 : p + 1'b1;
	endfunction

	// ring addresses
	assign wr_sum  = {1'b0, lh_start_q} + (AW + 1)'(look_fill_q);
	assign wr_addr = (wr_sum >= RING_W) ? AW'(wr_sum - RING_W) : wr_sum[AW-1:0];
	assign oldest_sum = (lh_start_q >= AW'(hist_fill_q)) ?
		{1'b0, lh_start_q} - (AW + 1)'(hist_fill_q) :
		{1'b0, lh_start_q} + RING_W - (AW + 1)'(hist_fill_q);
	assign oldest    = oldest_sum[AW-1:0];
	assign start_sum = {1'b0, lh_start_q} + (AW + 1)'(res_len_q);
	assign start_nxt = (start_sum >= RING_W) ? AW'(start_sum - RING_W) : start_sum[AW-1:0];

	// compare decision
	assign eq      = (rd_a_q == rd_b_q);
	assign no_hist = (hist_fill_q == '0);
	assign k_more  = ({1'b0, k_q} + 1'b1) < {1'b0, look_fill_q};
	assign i_more  = ({1'b0, i_q} + 1'b1) < {1'b0, hist_fill_q};
	assign text_len = 4'(TEXT_PUNCT) + 4'(dec_digits(32'(hist_fill_q - i_q)))
		+ 4'(dec_digits(32'(eq ? k_q + 1'b1 : k_q)));

	assign hist_sum = 32'(hist_fill_q) + 32'(res_len_q);

	assign st.look_empty       = (look_fill_q == '0);
	assign st.look_almost_full = (look_fill_q == LFW'(LOOKAHEAD_DEPTH - 1));
	assign st.scan_done        = no_hist || (eq && !k_more) || (!eq && (k_q != '0))
		|| (!eq && !i_more);
	assign st.out_free         = !out_valid_q || !out_stall;

	// storage
	always_ff @(posedge clk) begin
		if (cmd.push)
			ring_q[wr_addr] <= in_data.data_byte;
		if (cmd.read) begin
			rd_a_q <= ring_q[scan_ptr_q];
			rd_b_q <= ring_q[look_ptr_q];
		end
	end

	// scan registers and token result
	always_ff @(posedge clk) begin
		if (cmd.take)
			flush_q <= in_data.func;
		if (cmd.init) begin
			i_q        <= '0;
			k_q        <= '0;
			ptr_i_q    <= oldest;
			scan_ptr_q <= oldest;
			look_ptr_q <= lh_start_q;
		end
		if (cmd.compare) begin
			if (k_q == '0)
				res_lit_q <= rd_b_q;
			if (no_hist || (!eq && k_q == '0 && !i_more)) begin
				res_kind_q <= KIND_LITERAL;
				res_len_q  <= LFW'(1);
				res_off_q  <= '0;
			end else if (eq && k_more) begin
				k_q        <= k_q + 1'b1;
				scan_ptr_q <= wrap_inc(scan_ptr_q);
				look_ptr_q <= wrap_inc(look_ptr_q);
			end else if (eq || k_q != '0) begin
				res_off_q  <= hist_fill_q - i_q;
				res_len_q  <= eq ? k_q + 1'b1 : k_q;
				res_kind_q <= (32'(text_len) < 32'(eq ? k_q + 1'b1 : k_q)) ?
					KIND_REF : KIND_COPY;
			end else begin
				i_q        <= i_q + 1'b1;
				ptr_i_q    <= wrap_inc(ptr_i_q);
				scan_ptr_q <= wrap_inc(ptr_i_q);
				look_ptr_q <= lh_start_q;
			end
		end
		if (cmd.emit) begin
			out_q.token_kind   <= res_kind_q;
			out_q.match_offset <= 12'(res_off_q);
			out_q.match_length <= 9'(res_len_q);
			out_q.literal_byte <= (res_kind_q == KIND_LITERAL) ? res_lit_q : 8'd0;
			out_q.is_final     <= flush_q && (look_fill_q == res_len_q);
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lh_start_q  <= '0;
			hist_fill_q <= '0;
			look_fill_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.push)
				look_fill_q <= look_fill_q + 1'b1;
			if (cmd.emit) begin
				lh_start_q  <= start_nxt;
				look_fill_q <= look_fill_q - res_len_q;
				hist_fill_q <= (hist_sum >= 32'(SEARCH_DEPTH)) ?
					HFW'(SEARCH_DEPTH) : HFW'(hist_sum);
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
